FILE: hdl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

	localparam int DUTY_BITS_DEF        = 10;
	localparam int PRESS_COUNT_BITS_DEF = 16;
	localparam int DIM_COUNT_BITS_DEF   = 24;

	localparam int DEB_W   = 8;
	localparam int PRESS_W = 16;
	localparam int DIM_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IN_W    = 8;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 8'd20;
	localparam logic [PRESS_W-1:0] LONG_RST       = 16'd1000;
	localparam logic [PRESS_W-1:0] XLONG_RST      = 16'd5000;
	localparam logic [DIM_W-1:0]   DIM_HALF_RST   = 24'd30000;
	localparam logic [DIM_W-1:0]   DIM_QUART_RST  = 24'd30000;
	localparam logic [DIM_W-1:0]   DIM_OFF_RST    = 24'd60000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_LONG      = 3'd1,
		REG_XLONG     = 3'd2,
		REG_DIM_HALF  = 3'd3,
		REG_DIM_QUART = 3'd4,
		REG_DIM_OFF   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE       = 2'd0,
		EV_SHORT      = 2'd1,
		EV_LONG       = 2'd2,
		EV_EXTRA_LONG = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		DIM_FULL    = 2'd0,
		DIM_HALF    = 2'd1,
		DIM_QUARTER = 2'd2,
		DIM_OFF     = 2'd3
	} dim_stage_t;

	typedef struct packed {
		logic [DEB_W-1:0]   debounce_ticks;
		logic [PRESS_W-1:0] long_press_ticks;
		logic [PRESS_W-1:0] extra_long_press_ticks;
		logic [DIM_W-1:0]   dim_half_ticks;
		logic [DIM_W-1:0]   dim_quarter_ticks;
		logic [DIM_W-1:0]   dim_off_ticks;
	} cfg_t;

endpackage
`default_nettype wire

FILE: hdl/bpc_button.sv
`timescale 1ns / 1ps
`default_nettype none
module bpc_button import bpc_pkg::*; #(
	parameter int PRESS_COUNT_BITS = PRESS_COUNT_BITS_DEF,
	parameter bit IS_LINK          = 1'b0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   level,
	input  wire cfg_t   cfg,
	input  wire logic   was_full,
	output event_t      ev,
	output logic        released
);

	localparam int CW = (PRESS_COUNT_BITS > PRESS_W) ? PRESS_COUNT_BITS : PRESS_W;

	logic                        last_level_q;
	logic [DEB_W-1:0]            deb_cnt_q;
	logic [PRESS_COUNT_BITS-1:0] press_len_q;
	logic                        press_seen_q;

	logic                        last_level_d;
	logic [DEB_W-1:0]            deb_cnt_d;
	logic [DEB_W-1:0]            deb_dec;
	logic [PRESS_COUNT_BITS-1:0] press_len_d;
	logic [PRESS_COUNT_BITS-1:0] press_len_inc;
	logic                        press_seen_d;
	event_t                      cls;

	always_comb begin
		press_len_inc = press_len_q;
		if (press_seen_q && (press_len_q != '1))
			press_len_inc = press_len_q + PRESS_COUNT_BITS'(1);
		deb_dec = deb_cnt_q - DEB_W'(1);

		// release with no recorded press still counts as short
		cls = EV_SHORT;
		if (press_seen_q) begin
			priority if (IS_LINK && (CW'(press_len_inc) >= CW'(cfg.extra_long_press_ticks)))
				cls = EV_EXTRA_LONG;
			else if (CW'(press_len_inc) >= CW'(cfg.long_press_ticks))
				cls = EV_LONG;
			else
				cls = EV_SHORT;
		end
	end

	always_comb begin
		last_level_d = level;
		deb_cnt_d    = deb_cnt_q;
		press_len_d  = press_len_inc;
		press_seen_d = press_seen_q;
		ev           = EV_NONE;
		released     = 1'b0;
		if (deb_cnt_q != '0) begin
			deb_cnt_d = deb_dec;
			if (deb_dec == '0) begin
				press_len_d = '0;
				if (!level) begin
					press_seen_d = 1'b1;
				end else begin
					press_seen_d = 1'b0;
					released     = 1'b1;
					if (was_full)
						ev = cls;
				end
			end
		end else if (level != last_level_q) begin
			deb_cnt_d = (cfg.debounce_ticks == '0) ? DEB_W'(1) : cfg.debounce_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			deb_cnt_q    <= '0;
			press_len_q  <= '0;
			press_seen_q <= 1'b0;
		end else if (en) begin
			last_level_q <= last_level_d;
			deb_cnt_q    <= deb_cnt_d;
			press_len_q  <= press_len_d;
			press_seen_q <= press_seen_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/bpc_dimmer.sv
`timescale 1ns / 1ps
`default_nettype none
module bpc_dimmer import bpc_pkg::*; #(
	parameter int DUTY_BITS      = DUTY_BITS_DEF,
	parameter int DIM_COUNT_BITS = DIM_COUNT_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          release_any,
	input  wire cfg_t          cfg,
	output logic               was_full,
	output logic [DUTY_BITS-1:0] duty,
	output logic               full_nxt
);

	localparam int CW = (DIM_COUNT_BITS > DIM_W) ? DIM_COUNT_BITS : DIM_W;

	dim_stage_t                stage_q, stage_d;
	logic [DIM_COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic [DIM_W-1:0]          limit;

	assign was_full = (stage_q == DIM_FULL);

	always_comb begin
		unique case (stage_q)
			DIM_FULL:    limit = cfg.dim_half_ticks;
			DIM_HALF:    limit = cfg.dim_quarter_ticks;
			DIM_QUARTER: limit = cfg.dim_off_ticks;
			default:     limit = '0;
		endcase
		cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + DIM_COUNT_BITS'(1);
	end

	// next state
	always_comb begin
		stage_d = stage_q;
		cnt_d   = cnt_inc;
		priority if (release_any) begin
			stage_d = DIM_FULL;
			cnt_d   = '0;
		end else if (stage_q == DIM_OFF) begin
			cnt_d = '0;
		end else if (CW'(cnt_inc) >= CW'(limit)) begin
			stage_d = dim_stage_t'(stage_q + 2'd1);
			cnt_d   = '0;
		end else begin
			stage_d = stage_q;
			cnt_d   = cnt_inc;
		end
	end

	// outputs, taken from the stage after this tick
	always_comb begin
		full_nxt = (stage_d == DIM_FULL);
		unique case (stage_d)
			DIM_FULL:    duty = '1;
			DIM_HALF:    duty = DUTY_BITS'(1) << (DUTY_BITS - 1);
			DIM_QUARTER: duty = DUTY_BITS'(1) << (DUTY_BITS - 2);
			default:     duty = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= DIM_FULL;
			cnt_q   <= '0;
		end else if (en) begin
			stage_q <= stage_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/bpc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module bpc_cfg import bpc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr,
	input  wire logic [CFG_IDX_W-1:0]  idx,
	input  wire logic [CFG_DATA_W-1:0] data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks         <= DEBOUNCE_RST;
			cfg_q.long_press_ticks       <= LONG_RST;
			cfg_q.extra_long_press_ticks <= XLONG_RST;
			cfg_q.dim_half_ticks         <= DIM_HALF_RST;
			cfg_q.dim_quarter_ticks      <= DIM_QUART_RST;
			cfg_q.dim_off_ticks          <= DIM_OFF_RST;
		end else if (wr) begin
			unique case (idx)
				REG_DEBOUNCE:  cfg_q.debounce_ticks         <= data[DEB_W-1:0];
				REG_LONG:      cfg_q.long_press_ticks       <= data[PRESS_W-1:0];
				REG_XLONG:     cfg_q.extra_long_press_ticks <= data[PRESS_W-1:0];
				REG_DIM_HALF:  cfg_q.dim_half_ticks         <= data[DIM_W-1:0];
				REG_DIM_QUART: cfg_q.dim_quarter_ticks      <= data[DIM_W-1:0];
				REG_DIM_OFF:   cfg_q.dim_off_ticks          <= data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/button_press_classifier_with_dimmer.sv
`timescale 1ns / 1ps
// a result is registered and valid in the cycle after its input transaction
// throughput: one tick per cycle unless stalled; button and dimmer state update
// in the same cycle as the transaction; the result lands in one output register
// reset: arst_n clears all button and dimmer state, loads register defaults
// and empties the output register
`default_nettype none
module button_press_classifier_with_dimmer import bpc_pkg::*; #(
	parameter int DUTY_BITS        = DUTY_BITS_DEF,
	parameter int PRESS_COUNT_BITS = PRESS_COUNT_BITS_DEF,
	parameter int DIM_COUNT_BITS   = DIM_COUNT_BITS_DEF,
	localparam int OUT_W = ((6 + DUTY_BITS + 1 + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_W-1:0]       s_tdata,  // next_level, prev_level, link_level
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// next_event[1:0], prev_event, link_event, backlight_duty, at_full_brightness
	output logic [OUT_W-1:0]           m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                 cfg;
	logic                 acc;
	logic                 was_full;
	logic                 full_nxt;
	logic [DUTY_BITS-1:0] duty_nxt;
	event_t               ev [3];
	logic [2:0]           rel;

	logic                 m_valid_q;
	event_t               next_ev_q, prev_ev_q, link_ev_q;
	logic [DUTY_BITS-1:0] duty_q;
	logic                 full_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_valid_q || m_tready;
	assign acc       = s_tvalid && s_tready;

	bpc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid),
		.idx    (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	for (genvar b = 0; b < 3; b++) begin : g_btn
		bpc_button #(
			.PRESS_COUNT_BITS (PRESS_COUNT_BITS),
			.IS_LINK          (b == 2)
		) u_btn (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (acc),
			.level    (s_tdata[b]),
			.cfg      (cfg),
			.was_full (was_full),
			.ev       (ev[b]),
			.released (rel[b])
		);
	end

	bpc_dimmer #(
		.DUTY_BITS      (DUTY_BITS),
		.DIM_COUNT_BITS (DIM_COUNT_BITS)
	) u_dim (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (acc),
		.release_any (|rel),
		.cfg         (cfg),
		.was_full    (was_full),
		.duty        (duty_nxt),
		.full_nxt    (full_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (acc)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			next_ev_q <= ev[0];
			prev_ev_q <= ev[1];
			link_ev_q <= ev[2];
			duty_q    <= duty_nxt;
			full_q    <= full_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({full_q, duty_q, link_ev_q, prev_ev_q, next_ev_q});

	// at full brightness exactly when the duty is all ones
	a_full_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (full_q == (duty_q == '1)))
		else $error("brightness flag and duty disagree");

	// any reported event comes with a release, which restores full brightness
	a_event_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && ((next_ev_q != EV_NONE) || (prev_ev_q != EV_NONE) ||
			(link_ev_q != EV_NONE))) |-> full_q)
		else $error("event reported while not at full brightness");

	// only the link button classifies extra long
	a_no_xlong: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> ((next_ev_q != EV_EXTRA_LONG) && (prev_ev_q != EV_EXTRA_LONG)))
		else $error("extra long event on a non-link button");

	// an empty output register never stalls the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
`default_nettype wire

FILE: bench/button_press_classifier_with_dimmer_tb.sv
`timescale 1ns / 1ps
module button_press_classifier_with_dimmer_tb;
	import bpc_pkg::*;

	localparam int DUTY_W      = DUTY_BITS_DEF;
	localparam int OUT_W       = ((6 + DUTY_W + 1 + 7) / 8) * 8;
	localparam int STALL_LIMIT = 2000;
	localparam int GAP_PCT     = 16;

	// same bit order as m_tdata, lowest field last
	typedef struct packed {
		logic              full;
		logic [DUTY_W-1:0] duty;
		event_t            link_ev;
		event_t            prev_ev;
		event_t            next_ev;
	} tick_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_idx_t              cfg_index = REG_DEBOUNCE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic         calm = 1'b0;
	int           mismatches = 0;
	int           stall_cycles = 0;
	logic [2:0]   tick_levels[$];
	tick_result_t pending_results[$];

	// register copies
	logic [DEB_W-1:0]   deb_ticks   = DEBOUNCE_RST;
	logic [PRESS_W-1:0] long_ticks  = LONG_RST;
	logic [PRESS_W-1:0] xlong_ticks = XLONG_RST;
	logic [DIM_W-1:0]   half_ticks  = DIM_HALF_RST;
	logic [DIM_W-1:0]   quart_ticks = DIM_QUART_RST;
	logic [DIM_W-1:0]   off_ticks   = DIM_OFF_RST;

	// button and dimmer state, index 0 next, 1 prev, 2 link
	logic               btn_last[3]  = '{1'b1, 1'b1, 1'b1};
	logic [DEB_W-1:0]   btn_deb[3]   = '{'0, '0, '0};
	logic [PRESS_W-1:0] btn_len[3]   = '{'0, '0, '0};
	logic               btn_held[3]  = '{1'b0, 1'b0, 1'b0};
	dim_stage_t         light_stage  = DIM_FULL;
	logic [DIM_W-1:0]   light_count  = '0;

	button_press_classifier_with_dimmer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic tick_result_t classify_tick(logic [2:0] lvl);
		tick_result_t     r;
		logic             was_full;
		logic [DIM_W-1:0] lim;
		event_t           ev[3];
		event_t           e;
		was_full = (light_stage == DIM_FULL);
		ev = '{EV_NONE, EV_NONE, EV_NONE};
		if (light_stage == DIM_OFF) begin
			light_count = '0;
		end else begin
			lim = (light_stage == DIM_FULL) ? half_ticks :
			      (light_stage == DIM_HALF) ? quart_ticks : off_ticks;
			if (light_count != '1)
				light_count = light_count + 1'b1;
			if (light_count >= lim) begin
				light_stage = dim_stage_t'(light_stage + 2'd1);
				light_count = '0;
			end
		end
		for (int b = 0; b < 3; b++) begin
			if (btn_held[b] && btn_len[b] != '1)
				btn_len[b] = btn_len[b] + 1'b1;
			if (btn_deb[b] != '0) begin
				btn_deb[b] = btn_deb[b] - 1'b1;
				if (btn_deb[b] == '0) begin
					if (!lvl[b]) begin
						btn_held[b] = 1'b1;
						btn_len[b] = '0;
					end else begin
						// a release with no recorded press still counts as short
						e = EV_SHORT;
						if (btn_held[b]) begin
							if (b == 2 && btn_len[b] >= xlong_ticks)
								e = EV_EXTRA_LONG;
							else if (btn_len[b] >= long_ticks)
								e = EV_LONG;
						end
						btn_held[b] = 1'b0;
						btn_len[b] = '0;
						if (was_full)
							ev[b] = e;
						light_stage = DIM_FULL;
						light_count = '0;
					end
				end
			end else if (lvl[b] != btn_last[b]) begin
				btn_deb[b] = (deb_ticks == '0) ? DEB_W'(1) : deb_ticks;
			end
			btn_last[b] = lvl[b];
		end
		r.next_ev = ev[0];
		r.prev_ev = ev[1];
		r.link_ev = ev[2];
		case (light_stage)
			DIM_FULL:    r.duty = '1;
			DIM_HALF:    r.duty = DUTY_W'(1) << (DUTY_W - 1);
			DIM_QUARTER: r.duty = DUTY_W'(1) << (DUTY_W - 2);
			default:     r.duty = '0;
		endcase
		r.full = (light_stage == DIM_FULL);
		return r;
	endfunction

	function automatic void check_field(string name, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_val, got_val);
			mismatches++;
		end
	endfunction

	// driver: ticks go out in queue order, valid held until the transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_results.push_back(classify_tick(s_tdata[2:0]));
			if (!s_tvalid || s_tready) begin
				if (tick_levels.size() != 0 && (calm || $urandom_range(0, 99) >= GAP_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_W - 3){1'b0}}, tick_levels.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		tick_result_t want;
		tick_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = tick_result_t'(m_tdata[$bits(tick_result_t)-1:0]);
				if (pending_results.size() == 0) begin
					$display("%0t: result transaction with none expected, actual %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("next_event", want.next_ev, got.next_ev);
					check_field("prev_event", want.prev_ev, got.prev_ev);
					check_field("link_event", want.link_ev, got.link_ev);
					check_field("backlight_duty", want.duty, got.duty);
					check_field("at_full_brightness", want.full, got.full);
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DEBOUNCE:  deb_ticks = val[DEB_W-1:0];
			REG_LONG:      long_ticks = val[PRESS_W-1:0];
			REG_XLONG:     xlong_ticks = val[PRESS_W-1:0];
			REG_DIM_HALF:  half_ticks = val;
			REG_DIM_QUART: quart_ticks = val;
			REG_DIM_OFF:   off_ticks = val;
			default: ;
		endcase
	endtask

	task automatic set_timing(int deb, int lng, int xlng, int half, int quart, int off);
		write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
		write_reg(REG_LONG, CFG_DATA_W'(lng));
		write_reg(REG_XLONG, CFG_DATA_W'(xlng));
		write_reg(REG_DIM_HALF, CFG_DATA_W'(half));
		write_reg(REG_DIM_QUART, CFG_DATA_W'(quart));
		write_reg(REG_DIM_OFF, CFG_DATA_W'(off));
	endtask

	// sender holds off until every result is back
	task automatic drain();
		do @(posedge clk);
		while (tick_levels.size() != 0 || s_tvalid || pending_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// button activity: mostly clean presses and releases held past the debounce
	// window, with some glitches shorter than it
	task automatic queue_presses(int count, int deb, int press_span, int rest_span);
		logic [2:0] lvl;
		int         hold[3];
		lvl = 3'b111;
		for (int b = 0; b < 3; b++)
			hold[b] = $urandom_range(0, rest_span);
		for (int k = 0; k < count; k++) begin
			for (int b = 0; b < 3; b++) begin
				if (hold[b] == 0) begin
					lvl[b] = ~lvl[b];
					if ($urandom_range(0, 99) < 12)
						hold[b] = $urandom_range(1, deb);
					else if (!lvl[b])
						hold[b] = deb + $urandom_range(1, press_span);
					else
						hold[b] = deb + $urandom_range(1, rest_span);
				end
				hold[b]--;
			end
			tick_levels.push_back(lvl);
		end
	endtask

	initial begin
		// levels packed as {link, prev, next}
		logic [2:0] clean_seq[$] = '{3'b111, 3'b000, 3'b000, 3'b000, 3'b001, 3'b000,
			3'b001, 3'b011, 3'b011, 3'b011, 3'b011, 3'b011, 3'b010, 3'b011, 3'b111,
			3'b111, 3'b111, 3'b100, 3'b100, 3'b100, 3'b111, 3'b111, 3'b111};
		logic [2:0] dark_seq[$] = '{3'b111, 3'b111, 3'b111, 3'b111, 3'b110, 3'b110,
			3'b110, 3'b111, 3'b111, 3'b111, 3'b111};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults
		queue_presses(120, DEBOUNCE_RST, 30, 30);
		drain();

		// short press, long press, extra long link press, ignored edges,
		// release with no press, two releases in one tick
		set_timing(2, 4, 8, 20, 1, 1);
		tick_levels = clean_seq;
		drain();

		// dims to off, then a release while dark reports nothing
		set_timing(2, 4, 8, 1, 1, 1);
		tick_levels = dark_seq;
		drain();

		set_timing(3, 10, 25, 15, 5, 8);
		queue_presses(350, 3, 40, 40);
		drain();

		set_timing(1, 1, 1, 1, 1, 1);
		queue_presses(200, 1, 4, 4);
		drain();

		set_timing(255, 65535, 65535, 16777215, 16777215, 16777215);
		queue_presses(300, 255, 100, 100);
		drain();

		calm <= 1'b1;
		set_timing(6, 30, 60, 100, 40, 30);
		queue_presses(300, 6, 80, 150);
		drain();
		calm <= 1'b0;

		repeat (4) @(posedge clk);
		mismatches += pending_results.size();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
